FILE: hdl/rcd_pkg.sv
// Package for the remote-control frame decoder: sizes, codes, types and helper functions.
package rcd_pkg;

    // Frame and buffer geometry
    localparam int FRAME_BYTES  = 18;
    localparam int BUFFER_BYTES = 36;
    localparam int COUNT_W      = $clog2(BUFFER_BYTES + 1);
    localparam int IDX_W        = $clog2(FRAME_BYTES);

    // Field widths
    localparam int CH_W      = 11;
    localparam int CFG_IDX_W = 2;

    // Register reset values
    localparam logic [CH_W-1:0] LIMIT_RESET  = 11'd1684;
    localparam logic [CH_W-1:0] CENTER_RESET = 11'h400;

    // Both switches read 2 on an erroneous frame
    localparam logic [1:0] SWITCH_ERR       = 2'd2;
    localparam logic [3:0] SWITCHES_ON_ERR  = {SWITCH_ERR, SWITCH_ERR};

    // Divide by 10: multiply by ceil(2^16 / 10), exact for magnitudes below 16384
    localparam logic [12:0] VEL_RECIP       = 13'd6554;
    localparam int          VEL_SHIFT       = 16;
    localparam logic [7:0]  VEL_POS_MAX     = 8'd127;
    localparam logic [7:0]  VEL_NEG_MAG_MAX = 8'd128;
    localparam logic [7:0]  VEL_NEG_MIN     = 8'h80;

    // Input word codes
    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_IDLE = 1'b1
    } opcode_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STICK_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STICK_CENTER = 2'd1;

    typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

    // Status from the frame buffer
    typedef struct packed {
        logic               frame_done;
        logic [COUNT_W-1:0] byte_count;
    } fb_status_t;

    // One decoded result word
    typedef struct packed {
        logic [4*CH_W-1:0]  stick_channels;
        logic [3:0]         switches;
        logic signed [15:0] mouse_x;
        logic signed [15:0] mouse_y;
        logic signed [15:0] mouse_z;
        logic [15:0]        mouse_buttons;
        logic [15:0]        key_mask;
        logic signed [15:0] wheel_channel;
        logic signed [7:0]  vx_command;
        logic signed [7:0]  vy_command;
        logic signed [7:0]  wz_command;
        logic               frame_error;
    } result_t;

    // (channel - center) / 10, truncated toward zero, saturated to 8 bits
    function automatic logic signed [7:0] velocity(input logic [CH_W-1:0] ch,
                                                   input logic [CH_W-1:0] center);
        logic [CH_W:0]   diff;
        logic            neg;
        logic [CH_W-1:0] mag;
        logic [23:0]     prod;
        logic [7:0]      quo;
        logic [7:0]      res;
        diff = {1'b0, ch} - {1'b0, center};
        neg  = diff[CH_W];
        mag  = neg ? CH_W'((CH_W + 1)'(0) - diff) : diff[CH_W-1:0];
        prod = 24'(mag) * 24'(VEL_RECIP);
        quo  = prod[VEL_SHIFT+7:VEL_SHIFT];
        if (neg)
        begin
            res = (quo > VEL_NEG_MAG_MAX) ? VEL_NEG_MIN : 8'(8'd0 - quo);
        end
        else
        begin
            res = (quo > VEL_POS_MAX) ? VEL_POS_MAX : quo;
        end
        return $signed(res);
    endfunction

endpackage

FILE: hdl/rcd_if.sv
// Channel interfaces of the frame decoder: input words, result words, register writes.
interface rcd_item_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] data_byte;

    modport source (output valid, output opcode, output data_byte, input ready);
    modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

interface rcd_result_if;
    logic               valid;
    logic               ready;
    logic [43:0]        stick_channels;
    logic [3:0]         switches;
    logic signed [15:0] mouse_x;
    logic signed [15:0] mouse_y;
    logic signed [15:0] mouse_z;
    logic [15:0]        mouse_buttons;
    logic [15:0]        key_mask;
    logic signed [15:0] wheel_channel;
    logic signed [7:0]  vx_command;
    logic signed [7:0]  vy_command;
    logic signed [7:0]  wz_command;
    logic               frame_error;

    modport source (output valid, input ready, output stick_channels, output switches,
                    output mouse_x, output mouse_y, output mouse_z, output mouse_buttons,
                    output key_mask, output wheel_channel, output vx_command,
                    output vy_command, output wz_command, output frame_error);
    modport sink   (input valid, output ready, input stick_channels, input switches,
                    input mouse_x, input mouse_y, input mouse_z, input mouse_buttons,
                    input key_mask, input wheel_channel, input vx_command,
                    input vy_command, input wz_command, input frame_error);
endinterface

interface rcd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [10:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/rcd_frame_buffer.sv
// Frame buffer: stores received bytes and counts them until the line goes idle.
module rcd_frame_buffer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic                opcode,
    input  logic [7:0]          data_byte,
    output rcd_pkg::frame_t     frame,
    output rcd_pkg::fb_status_t status
);

    rcd_pkg::frame_t                 frame_reg;
    logic [rcd_pkg::COUNT_W-1:0]     count_reg;
    logic [rcd_pkg::COUNT_W-1:0]     count_next;
    logic                            is_byte;
    logic                            is_idle;

    assign is_byte = in_fire && (opcode == rcd_pkg::OP_BYTE);
    assign is_idle = in_fire && (opcode == rcd_pkg::OP_IDLE);

    // Advance the count on a byte, saturate at the buffer size, drop to zero on idle
    always_comb
    begin
        count_next = count_reg;
        if (is_idle)
        begin
            count_next = '0;
        end
        else if (is_byte && (count_reg < rcd_pkg::COUNT_W'(rcd_pkg::BUFFER_BYTES)))
        begin
            count_next = count_reg + rcd_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Store the first frame's worth of bytes; drop the rest
    always_ff @(posedge clk)
    begin
        if (is_byte && (count_reg < rcd_pkg::COUNT_W'(rcd_pkg::FRAME_BYTES)))
        begin
            frame_reg[count_reg[rcd_pkg::IDX_W-1:0]] <= data_byte;
        end
    end

    assign frame             = frame_reg;
    assign status.byte_count = count_reg;
    assign status.frame_done = is_idle &&
                               (count_reg == rcd_pkg::COUNT_W'(rcd_pkg::FRAME_BYTES));

endmodule

FILE: hdl/rcd_decoder.sv
// Decoder: unpacks a stored frame, checks stick limits and scales velocity commands.
module rcd_decoder (
    input  rcd_pkg::frame_t             frame,
    input  logic [rcd_pkg::CH_W-1:0]    stick_limit,
    input  logic [rcd_pkg::CH_W-1:0]    stick_center,
    output rcd_pkg::result_t            result
);

    logic [rcd_pkg::CH_W-1:0] ch0;
    logic [rcd_pkg::CH_W-1:0] ch1;
    logic [rcd_pkg::CH_W-1:0] ch2;
    logic [rcd_pkg::CH_W-1:0] ch3;
    logic                     err;

    // Unpack the 11-bit stick channels from the first six bytes
    assign ch0 = {frame[1][2:0], frame[0]};
    assign ch1 = {frame[2][5:0], frame[1][7:3]};
    assign ch2 = {frame[4][0], frame[3], frame[2][7:6]};
    assign ch3 = {frame[5][3:0], frame[4][7:1]};

    assign err = (ch0 > stick_limit) || (ch1 > stick_limit) ||
                 (ch2 > stick_limit) || (ch3 > stick_limit);

    // Clear the decoded fields on error; velocity always comes from the raw channels
    always_comb
    begin
        result.vx_command  = rcd_pkg::velocity(ch3, stick_center);
        result.vy_command  = rcd_pkg::velocity(ch2, stick_center);
        result.wz_command  = rcd_pkg::velocity(ch0, stick_center);
        result.frame_error = err;
        if (err)
        begin
            result.stick_channels = '0;
            result.switches       = rcd_pkg::SWITCHES_ON_ERR;
            result.mouse_x        = '0;
            result.mouse_y        = '0;
            result.mouse_z        = '0;
            result.mouse_buttons  = '0;
            result.key_mask       = '0;
            result.wheel_channel  = '0;
        end
        else
        begin
            result.stick_channels = {ch3, ch2, ch1, ch0};
            result.switches       = frame[5][7:4];
            result.mouse_x        = $signed({frame[7], frame[6]});
            result.mouse_y        = $signed({frame[9], frame[8]});
            result.mouse_z        = $signed({frame[11], frame[10]});
            result.mouse_buttons  = {frame[13], frame[12]};
            result.key_mask       = {frame[15], frame[14]};
            result.wheel_channel  = $signed({frame[17], frame[16]});
        end
    end

endmodule

FILE: hdl/rcd_output_stage.sv
// Output stage: result register with a skid register behind it.
module rcd_output_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rcd_pkg::result_t result,
    output logic             can_accept,
    rcd_result_if.source     result_out
);

    rcd_pkg::result_t main_reg;
    rcd_pkg::result_t skid_reg;
    logic             main_valid_reg;
    logic             main_valid_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    logic             main_free;

    assign main_free = !main_valid_reg || result_out.ready;

    // Refill the result register from skid first, else from a new push
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (main_free)
        begin
            if (skid_valid_reg)
            begin
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload moves
    always_ff @(posedge clk)
    begin
        if (main_free)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
            end
            else if (push)
            begin
                main_reg <= result;
            end
        end
        else if (push)
        begin
            skid_reg <= result;
        end
    end

    assign can_accept = !skid_valid_reg;

    assign result_out.valid          = main_valid_reg;
    assign result_out.stick_channels = main_reg.stick_channels;
    assign result_out.switches       = main_reg.switches;
    assign result_out.mouse_x        = main_reg.mouse_x;
    assign result_out.mouse_y        = main_reg.mouse_y;
    assign result_out.mouse_z        = main_reg.mouse_z;
    assign result_out.mouse_buttons  = main_reg.mouse_buttons;
    assign result_out.key_mask       = main_reg.key_mask;
    assign result_out.wheel_channel  = main_reg.wheel_channel;
    assign result_out.vx_command     = main_reg.vx_command;
    assign result_out.vy_command     = main_reg.vy_command;
    assign result_out.wz_command     = main_reg.wz_command;
    assign result_out.frame_error    = main_reg.frame_error;

endmodule

FILE: hdl/rc_receiver_frame_decoder.sv
// Top level of the remote-control receiver frame decoder.
//
// item_in takes one word per cycle while ready: opcode 0 carries a received byte, opcode 1
// marks the line going idle. Bytes fill an 18-byte frame store; the count
// saturates at 36. An idle word after exactly 18 bytes yields one result word
// on result_out; any idle word restarts the count, and other counts give nothing.
// cfg writes stick_limit (index 0) and stick_center (index 1); it is always
// ready and writes to other indexes are ignored.
// Accepting the idle word registers the result into the result register, or into the skid
// register while that is held. Throughput: one input word per cycle while ready is high,
// set by the single register write into the frame store and one decode from the stored frame.
// When result_out stalls, the result register holds and one more result goes
// into a skid register; item_in.ready drops only while the skid register is
// full, and rises again the cycle after the result register drains.
// Reset clears the byte count and both output valids and loads stick_limit
// with 1684 and stick_center with 1024.
module rc_receiver_frame_decoder (
    input  logic         clk,
    input  logic         rst_n,
    rcd_item_if.sink     item_in,
    rcd_result_if.source result_out,
    rcd_cfg_if.sink      cfg
);

    logic [rcd_pkg::CH_W-1:0] stick_limit_reg;
    logic [rcd_pkg::CH_W-1:0] stick_center_reg;
    logic                     in_fire;
    logic                     can_accept;
    rcd_pkg::frame_t          frame;
    rcd_pkg::fb_status_t      fb_status;
    rcd_pkg::result_t         decoded;

    assign cfg.ready     = 1'b1;
    assign item_in.ready = can_accept;
    assign in_fire       = item_in.valid && item_in.ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stick_limit_reg  <= rcd_pkg::LIMIT_RESET;
            stick_center_reg <= rcd_pkg::CENTER_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                rcd_pkg::REG_STICK_LIMIT:  stick_limit_reg  <= cfg.data;
                rcd_pkg::REG_STICK_CENTER: stick_center_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    rcd_frame_buffer u_frame_buffer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .opcode    (item_in.opcode),
        .data_byte (item_in.data_byte),
        .frame     (frame),
        .status    (fb_status)
    );

    rcd_decoder u_decoder (
        .frame        (frame),
        .stick_limit  (stick_limit_reg),
        .stick_center (stick_center_reg),
        .result       (decoded)
    );

    rcd_output_stage u_output_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (fb_status.frame_done),
        .result     (decoded),
        .can_accept (can_accept),
        .result_out (result_out)
    );

`ifndef SYNTHESIS
    // A frame completes only on an accepted idle word
    assert property (@(posedge clk) disable iff (!rst_n)
        fb_status.frame_done |-> (in_fire && (item_in.opcode == rcd_pkg::OP_IDLE)))
        else $error("frame done without an accepted idle word");

    // The byte count never passes the buffer size
    assert property (@(posedge clk) disable iff (!rst_n)
        fb_status.byte_count <= rcd_pkg::COUNT_W'(rcd_pkg::BUFFER_BYTES))
        else $error("byte count above buffer size");

    // An accepted idle word restarts the count
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (item_in.opcode == rcd_pkg::OP_IDLE)) |=> (fb_status.byte_count == '0))
        else $error("byte count not cleared after idle");

    // An erroneous result carries cleared sticks and the error switch code
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && result_out.frame_error) |->
        ((result_out.stick_channels == '0) &&
         (result_out.switches == rcd_pkg::SWITCHES_ON_ERR)))
        else $error("erroneous result not cleared");
`endif

endmodule

FILE: tb/sv/rcd_frame_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the frame decoder: tracks the frame store, predicts each result word and compares.
module rcd_frame_checker (
    input  logic  clk,
    input  logic  rst_n,
    rcd_item_if   item_bus,
    rcd_result_if result_bus,
    rcd_cfg_if    cfg_bus,
    output int    mismatches,
    output int    pending
);
    import rcd_pkg::*;

    localparam int SPEED_DIV  = 10;
    localparam int SPEED_HI   = 127;
    localparam int SPEED_LO   = -128;
    localparam int REPORT_MAX = 10;

    // Shadow of the registers and the frame store
    logic [CH_W-1:0] limit_reg;
    logic [CH_W-1:0] center_reg;
    logic [7:0]      frame_bytes [FRAME_BYTES];
    int              fill;
    result_t         awaited [$];
    int              fail_count;

    // Stick deflection scaled to a velocity word, truncated toward zero and clamped
    function automatic logic signed [7:0] speed_cmd(input logic [CH_W-1:0] ch);
        int q;
        q = (int'(ch) - int'(center_reg)) / SPEED_DIV;
        if (q > SPEED_HI)
            q = SPEED_HI;
        else if (q < SPEED_LO)
            q = SPEED_LO;
        return 8'(q);
    endfunction

    // Unpack the stored frame into the result word the block should emit
    function automatic result_t decode_frame();
        result_t         r;
        logic [47:0]     head;
        logic [CH_W-1:0] ch [4];
        logic            bad;
        head = {frame_bytes[5], frame_bytes[4], frame_bytes[3],
                frame_bytes[2], frame_bytes[1], frame_bytes[0]};
        bad = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            ch[k] = head[CH_W*k +: CH_W];
            if (ch[k] > limit_reg)
                bad = 1'b1;
        end
        r.vx_command  = speed_cmd(ch[3]);
        r.vy_command  = speed_cmd(ch[2]);
        r.wz_command  = speed_cmd(ch[0]);
        r.frame_error = bad;
        if (bad)
        begin
            r.stick_channels = '0;
            r.switches       = SWITCHES_ON_ERR;
            r.mouse_x        = '0;
            r.mouse_y        = '0;
            r.mouse_z        = '0;
            r.mouse_buttons  = '0;
            r.key_mask       = '0;
            r.wheel_channel  = '0;
        end
        else
        begin
            r.stick_channels = {ch[3], ch[2], ch[1], ch[0]};
            r.switches       = frame_bytes[5][7:4];
            r.mouse_x        = {frame_bytes[7], frame_bytes[6]};
            r.mouse_y        = {frame_bytes[9], frame_bytes[8]};
            r.mouse_z        = {frame_bytes[11], frame_bytes[10]};
            r.mouse_buttons  = {frame_bytes[13], frame_bytes[12]};
            r.key_mask       = {frame_bytes[15], frame_bytes[14]};
            r.wheel_channel  = {frame_bytes[17], frame_bytes[16]};
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Follow register writes and input words, then check each result word
    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            limit_reg  = LIMIT_RESET;
            center_reg = CENTER_RESET;
            fill       = 0;
            fail_count = 0;
            awaited.delete();
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                case (cfg_bus.index)
                    REG_STICK_LIMIT:  limit_reg  = cfg_bus.data;
                    REG_STICK_CENTER: center_reg = cfg_bus.data;
                    default: ;
                endcase
            end

            if (item_bus.valid && item_bus.ready)
            begin
                if (item_bus.opcode == OP_BYTE)
                begin
                    // keep only the first frame's worth, saturate the count
                    if (fill < FRAME_BYTES)
                        frame_bytes[fill] = item_bus.data_byte;
                    if (fill < BUFFER_BYTES)
                        fill++;
                end
                else
                begin
                    if (fill == FRAME_BYTES)
                        awaited.push_back(decode_frame());
                    fill = 0;
                end
            end

            if (result_bus.valid && result_bus.ready)
            begin
                got.stick_channels = result_bus.stick_channels;
                got.switches       = result_bus.switches;
                got.mouse_x        = result_bus.mouse_x;
                got.mouse_y        = result_bus.mouse_y;
                got.mouse_z        = result_bus.mouse_z;
                got.mouse_buttons  = result_bus.mouse_buttons;
                got.key_mask       = result_bus.key_mask;
                got.wheel_channel  = result_bus.wheel_channel;
                got.vx_command     = result_bus.vx_command;
                got.vy_command     = result_bus.vy_command;
                got.wz_command     = result_bus.wz_command;
                got.frame_error    = result_bus.frame_error;
                if (awaited.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("%0t: result word with none outstanding", $time);
                end
                else
                begin
                    want = awaited.pop_front();
                    compare_field("stick_channels", 64'(want.stick_channels),
                                  64'(got.stick_channels));
                    compare_field("switches", 64'(want.switches), 64'(got.switches));
                    compare_field("mouse_x", 64'(want.mouse_x), 64'(got.mouse_x));
                    compare_field("mouse_y", 64'(want.mouse_y), 64'(got.mouse_y));
                    compare_field("mouse_z", 64'(want.mouse_z), 64'(got.mouse_z));
                    compare_field("mouse_buttons", 64'(want.mouse_buttons),
                                  64'(got.mouse_buttons));
                    compare_field("key_mask", 64'(want.key_mask), 64'(got.key_mask));
                    compare_field("wheel_channel", 64'(want.wheel_channel),
                                  64'(got.wheel_channel));
                    compare_field("vx_command", 64'(want.vx_command), 64'(got.vx_command));
                    compare_field("vy_command", 64'(want.vy_command), 64'(got.vy_command));
                    compare_field("wz_command", 64'(want.wz_command), 64'(got.wz_command));
                    compare_field("frame_error", 64'(want.frame_error),
                                  64'(got.frame_error));
                end
            end

            mismatches <= fail_count;
            pending    <= awaited.size();
        end
    end

endmodule

FILE: tb/sv/rc_receiver_frame_decoder_tb.sv
`timescale 1ns / 1ps
// Testbench top for the frame decoder: clock, reset, stimulus, output stalls and the verdict.
module rc_receiver_frame_decoder_tb;
    import rcd_pkg::*;

    // Register indexes past the end of the list; writes there are ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam logic [CH_W-1:0] STICK_MAX = 11'h7FF;
    localparam int HOLD_CYCLES  = 150;
    localparam int PHASE_WORDS  = 130;
    localparam int MIN_FRAMES   = 16;
    localparam int LATENCY_PAD  = 4;
    localparam int TIMEOUT_NS   = 2_000_000;

    logic clk;
    logic rst_n;

    rcd_item_if   item_bus ();
    rcd_result_if result_bus ();
    rcd_cfg_if    cfg_bus ();

    int              mismatches;
    int              pending;
    int              words_sent;
    int              good_frames;
    int              quiet_words;
    logic [CH_W-1:0] cur_limit;
    logic [CH_W-1:0] cur_center;
    bit              calm;
    bit              hold_req;
    bit              hold_done;

    rc_receiver_frame_decoder uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_bus),
        .result_out (result_bus),
        .cfg        (cfg_bus)
    );

    rcd_frame_checker frame_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_bus   (item_bus),
        .result_bus (result_bus),
        .cfg_bus    (cfg_bus),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

    // Offer one word, with an occasional burst of idle cycles ahead of it
    task automatic send_word(input opcode_t op, input logic [7:0] value);
        int gap;
        if (!calm)
        begin
            if (quiet_words > 0)
                quiet_words--;
            else if ($urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 5);
                item_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
                if ($urandom_range(0, 2) == 0)
                    quiet_words = $urandom_range(10, 40);
            end
        end
        item_bus.valid     <= 1'b1;
        item_bus.opcode    <= op;
        item_bus.data_byte <= value;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        words_sent++;
    endtask

    // Pack sticks, switches and payload into frame bytes; send nbytes of them, then idle
    task automatic send_frame(input logic [CH_W-1:0] c0, input logic [CH_W-1:0] c1,
                              input logic [CH_W-1:0] c2, input logic [CH_W-1:0] c3,
                              input logic [3:0] sw, input logic [95:0] tail,
                              input int nbytes);
        logic [143:0] flat;
        flat = {tail, sw, c3, c2, c1, c0};
        for (int k = 0; k < nbytes; k++)
            send_word(OP_BYTE, (k < FRAME_BYTES) ? flat[8*k +: 8] : 8'($urandom));
        send_word(OP_IDLE, 8'($urandom));
    endtask

    // Stick value biased toward the limit edges and the range ends
    function automatic logic [CH_W-1:0] pick_stick();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return cur_limit;
            2:       return (cur_limit == STICK_MAX) ? cur_limit : cur_limit + 11'd1;
            3:       return STICK_MAX;
            default: return CH_W'($urandom_range(0, cur_limit));
        endcase
    endfunction

    // Write both registers, optionally also the unused indexes, then drop valid
    task automatic program_regs(input logic [CH_W-1:0] lim, input logic [CH_W-1:0] ctr,
                                input bit with_spare);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [CH_W-1:0]      val [4];
        int                   n;
        idx = '{REG_STICK_LIMIT, REG_STICK_CENTER, REG_SPARE_A, REG_SPARE_B};
        val = '{lim, ctr, CH_W'($urandom), CH_W'($urandom)};
        n = with_spare ? 4 : 2;
        for (int k = 0; k < n; k++)
        begin
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= idx[k];
            cfg_bus.data  <= val[k];
            @(posedge clk);
            while (!cfg_bus.ready)
                @(posedge clk);
        end
        cfg_bus.valid <= 1'b0;
        cur_limit  = lim;
        cur_center = ctr;
    endtask

    // Stop offering words and wait for every expected result, then wait out the LATENCY_PAD margin
    task automatic wait_drained();
        item_bus.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY_PAD) @(posedge clk);
    endtask

    // One random sequence: mostly proper frames, some wrong lengths and line noise
    task automatic random_burst();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 70)
        begin
            send_frame(pick_stick(), pick_stick(), pick_stick(), pick_stick(), 4'($urandom),
                       {$urandom, $urandom, $urandom}, FRAME_BYTES);
            good_frames++;
        end
        else if (kind < 80)
            send_frame(pick_stick(), pick_stick(), pick_stick(), pick_stick(), 4'($urandom),
                       {$urandom, $urandom, $urandom},
                       $urandom_range(0, 1) ? FRAME_BYTES - 1 : FRAME_BYTES + 1);
        else if (kind < 88)
        begin
            n = $urandom_range(0, BUFFER_BYTES + 10);
            repeat (n) send_word(OP_BYTE, 8'($urandom));
            send_word(OP_IDLE, 8'($urandom));
        end
        else
            send_word(OP_IDLE, 8'($urandom));
    endtask

    task automatic run_phase(input int words);
        int start;
        start = words_sent;
        while (words_sent - start < words)
            random_burst();
    endtask

    // Result side: short random stalls, quiet stretches, and one long hold-off
    initial
    begin
        int stall_left;
        int steady_left;
        stall_left  = 0;
        steady_left = 0;
        hold_done   = 1'b0;
        result_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                result_bus.ready <= 1'b0;
            end
            else if (hold_req && !hold_done)
            begin
                // hold long enough for the skid register to fill and stall the input
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES - 1;
                result_bus.ready <= 1'b0;
            end
            else if (!calm && steady_left == 0 && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 5) - 1;
                if ($urandom_range(0, 2) == 0)
                    steady_left = $urandom_range(20, 60);
                result_bus.ready <= 1'b0;
            end
            else
            begin
                if (steady_left > 0)
                    steady_left--;
                result_bus.ready <= 1'b1;
            end
        end
    end

    // Stimulus
    initial
    begin
        item_bus.valid     = 1'b0;
        item_bus.opcode    = OP_BYTE;
        item_bus.data_byte = '0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = REG_STICK_LIMIT;
        cfg_bus.data       = '0;
        words_sent  = 0;
        good_frames = 0;
        quiet_words = 0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        cur_limit   = LIMIT_RESET;
        cur_center  = CENTER_RESET;

        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sticks right at the limit, payload at its signed and unsigned extremes
        send_frame(LIMIT_RESET, 11'd0, CENTER_RESET, LIMIT_RESET - 11'd1, 4'hF,
                   {8'h80, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF,
                    8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'h80, 8'h00}, FRAME_BYTES);
        // one stick just over the limit and one at the top: cleared fields, velocities still from raw sticks
        send_frame(11'd0, LIMIT_RESET + 11'd1, STICK_MAX, 11'd0, 4'h0, {12{8'h5A}},
                   FRAME_BYTES);
        // short frame and a bare idle give nothing
        send_frame(pick_stick(), pick_stick(), pick_stick(), pick_stick(), 4'($urandom),
                   {$urandom, $urandom, $urandom}, FRAME_BYTES - 1);
        send_word(OP_IDLE, 8'hFF);
        // long burst past the buffer size, then a proper frame after the restart
        repeat (BUFFER_BYTES + 4) send_word(OP_BYTE, 8'($urandom));
        send_word(OP_IDLE, 8'h00);
        send_frame(pick_stick(), pick_stick(), pick_stick(), pick_stick(), 4'($urandom),
                   {$urandom, $urandom, $urandom}, FRAME_BYTES);
        wait_drained();

        // no limit, center at zero: large positive velocities clamp
        program_regs(STICK_MAX, 11'd0, 1'b0);
        run_phase(PHASE_WORDS);
        wait_drained();

        // limit at zero, center at the top: negative velocities clamp
        program_regs(11'd0, STICK_MAX, 1'b1);
        run_phase(PHASE_WORDS);
        wait_drained();

        // random settings while the result side holds off for a long stretch
        program_regs(CH_W'($urandom), CH_W'($urandom), 1'b0);
        hold_req <= 1'b1;
        run_phase(PHASE_WORDS);
        wait_drained();

        // back to reset values, full rate on both sides
        program_regs(LIMIT_RESET, CENTER_RESET, 1'b1);
        calm = 1'b1;
        run_phase(PHASE_WORDS);
        while (good_frames < MIN_FRAMES)
            random_burst();
        wait_drained();

        if (mismatches == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
